>>> rtl/modular_inverse_macros.svh
// Assertion macros shared by the modular inverse block.
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// Checked property that is skipped while reset is high.
`define MI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define MI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/modinv_pkg.sv
// Types and constants shared by the modular inverse block.
package modinv_pkg;

  localparam int WORD_BITS = 31;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t CNT_LAST = cnt_t'(WORD_BITS - 1);

  // Input word.
  typedef struct packed {
    word_t value_in;
    word_t modulus;
  } in_word_t;

  // Result word.
  typedef struct packed {
    word_t inverse;
    logic  zero_input;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic update;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic value_zero;
    logic rem_zero;
  } dp_sts_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

>>> rtl/modular_inverse.sv
// Modular inverse by continued-fraction expansion: one word in, one word out.
// Each Euclid step finds one quotient bit per cycle, then does one numerator update.
// A word takes k quotient steps, k below 1.45*WORD_BITS+1; a zero value skips the
// division and goes straight to the result. One word at a time.
// The result shows for one cycle with done and cannot be stalled; a new word may
// start in that cycle. Synchronous reset clears the controller and the strobe.
module modular_inverse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  modinv_pkg::in_word_t  item,
  output logic                 busy,
  output logic                 done,
  output modinv_pkg::out_word_t result
);
  import modinv_pkg::*;

  `include "modular_inverse_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  modinv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  modinv_dp u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  // Checks on the controller and datapath cooperation.
  `MI_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not make block busy")
  `MI_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
  `MI_ASSERT(a_zero_result, (done && result.zero_input) |-> (result.inverse == '0), "zero value gave nonzero inverse")
  `MI_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.step, cmd.update, cmd.finish}), "datapath commands overlap")

endmodule

>>> rtl/modinv_dp.sv
// Datapath: bit-serial division with a fused shift-add for the convergent numerators.
module modinv_dp (
  input  logic                clk,
  input  modinv_pkg::in_word_t item,
  input  modinv_pkg::dp_cmd_t  cmd,
  output modinv_pkg::dp_sts_t  sts,
  output modinv_pkg::out_word_t result
);
  import modinv_pkg::*;

  word_t                divd;
  word_t                divs;
  logic [WORD_BITS:0]   rem;
  word_t                acc;
  word_t                cur;
  word_t                prev;
  word_t                mod;
  logic                 odd;
  logic                 zero;

  logic [WORD_BITS:0]   rem_sh;
  logic                 q_bit;
  word_t                acc_sh;

  // One restoring division step; the quotient bit feeds a Horner product with cur.
  always_comb begin
    rem_sh = {rem[WORD_BITS-1:0], divd[WORD_BITS-1]};
    q_bit  = (rem_sh >= {1'b0, divs});
    acc_sh = {acc[WORD_BITS-2:0], 1'b0};
  end

  // Working registers of the continued-fraction expansion.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divd <= item.modulus;
      divs <= item.value_in;
      mod  <= item.modulus;
      rem  <= '0;
      acc  <= '0;
      cur  <= word_t'(1);
      prev <= '0;
      odd  <= 1'b1;
      zero <= (item.value_in == '0);
    end else if (cmd.step) begin
      divd <= {divd[WORD_BITS-2:0], 1'b0};
      rem  <= q_bit ? (rem_sh - {1'b0, divs}) : rem_sh;
      acc  <= acc_sh + (q_bit ? cur : '0);
    end else if (cmd.update) begin
      divd <= divs;
      divs <= rem[WORD_BITS-1:0];
      cur  <= acc + prev;
      prev <= cur;
      odd  <= ~odd;
      rem  <= '0;
      acc  <= '0;
    end
  end

  // Result register, loaded once the expansion has ended.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (zero) begin
        result.inverse    <= '0;
        result.zero_input <= 1'b1;
      end else begin
        result.inverse    <= odd ? (mod - prev) : prev;
        result.zero_input <= 1'b0;
      end
    end
  end

  assign sts.value_zero = (item.value_in == '0);
  assign sts.rem_zero   = (rem == '0);

endmodule

>>> rtl/modinv_ctrl.sv
// Controller: sequences division steps, numerator updates and the result word.
module modinv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  modinv_pkg::dp_sts_t  sts,
  output modinv_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import modinv_pkg::*;

  state_t state;
  state_t state_next;
  cnt_t   cnt;
  cnt_t   cnt_next;
  logic   done_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    done_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = CNT_LAST;
          state_next = sts.value_zero ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_UPD;
        end else begin
          cnt_next = cnt - cnt_t'(1);
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        cnt_next   = CNT_LAST;
        state_next = sts.rem_zero ? ST_FIN : ST_DIV;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, bit counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> tb/sv/modinv_checker.sv
// Checker for the modular inverse block: predicts each inverse and compares results.
module modinv_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  modinv_pkg::in_word_t  item,
  input  logic                  done,
  input  modinv_pkg::out_word_t result,
  output int                    fail_count,
  output int                    pending
);
  import modinv_pkg::*;

  // Inverses predicted for accepted words, oldest first.
  out_word_t inverse_queue[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Continued-fraction expansion of modulus / value, keeping the last two
  // convergent numerators and the parity of the number of quotient steps.
  function automatic out_word_t predict_inverse(in_word_t w);
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [63:0] cur;
    logic [63:0] prev;
    logic [63:0] nxt;
    logic        odd;
    out_word_t   res;
    v = 64'(w.value_in);
    m = 64'(w.modulus);
    res.inverse    = '0;
    res.zero_input = (v == 64'd0);
    if (v != 64'd0) begin
      q        = m / v;
      r        = m - q * v;
      dividend = v;
      divisor  = r;
      cur      = q;
      prev     = 64'd1;
      odd      = 1'b0;
      while (r != 64'd0) begin
        q        = dividend / divisor;
        r        = dividend - q * divisor;
        nxt      = q * cur + prev;
        prev     = cur;
        cur      = nxt;
        dividend = divisor;
        divisor  = r;
        odd      = ~odd;
      end
      res.inverse = word_t'(odd ? (m - prev) : prev);
    end
    return res;
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Results are checked before the new word is queued, since a word may be
  // accepted in the same cycle that the previous result shows.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst) begin
      if (done) begin
        if (inverse_queue.size() == 0) begin
          report_mismatch("result with no word outstanding", 64'(result), 64'd0);
        end else begin
          want = inverse_queue.pop_front();
          if (result.inverse !== want.inverse)
            report_mismatch("inverse", 64'(result.inverse), 64'(want.inverse));
          if (result.zero_input !== want.zero_input)
            report_mismatch("zero_input", 64'(result.zero_input), 64'(want.zero_input));
        end
      end
      if (start && !busy) inverse_queue.push_back(predict_inverse(item));
    end
    pending <= inverse_queue.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the modular inverse block: stimulus, clock, reset and verdict.
module tb;
  import modinv_pkg::*;

  localparam int N_RANDOM     = 1330;
  localparam int MAX_LATENCY  = 47 * (WORD_BITS + 1) + 2;
  localparam int MAX_GAP      = 600;
  localparam int CYCLE_LIMIT  = 3 * (N_RANDOM + 64) * (MAX_LATENCY + MAX_GAP);
  localparam int DRAIN_CYCLES = 64;
  localparam word_t WORD_MAX  = '1;

  logic      clk;
  logic      rst;
  logic      start;
  in_word_t  item;
  logic      busy;
  logic      done;
  out_word_t result;
  int        fail_count;
  int        pending;
  int        cycles;

  modular_inverse u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  modinv_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with a period of 4.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Idle cycles before the next word: mostly short runs, none for words 500 to 699,
  // sometimes a long pause that lets the block go idle first.
  function automatic int pick_gap(int idx);
    int gap;
    gap = 0;
    if (idx >= 500 && idx < 700) return 0;
    if ($urandom_range(99) < 8) return $urandom_range(MAX_GAP, 1);
    while ($urandom_range(99) < 35 && gap < 40) gap++;
    return gap;
  endfunction

  // Holds start low for the gap with noise on the bus, then offers the word
  // and waits until the block is not busy.
  task automatic send_word(in_word_t w, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      item  <= '{value_in: word_t'($urandom()), modulus: word_t'($urandom())};
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random word of a given width.
  function automatic word_t rand_bits(int width);
    word_t mask;
    mask = word_t'((64'd1 << width) - 64'd1);
    return word_t'($urandom()) & mask;
  endfunction

  // Mostly well-formed pairs: modulus usually odd, value nonzero and below it.
  // The rest are zero values, unconstrained random values and tiny moduli of 0 or 1.
  function automatic in_word_t random_word();
    in_word_t w;
    int       width;
    int       kind;
    width = ($urandom_range(99) < 60) ? WORD_BITS : $urandom_range(16, 2);
    kind  = $urandom_range(99);
    w.modulus = rand_bits(width);
    if ($urandom_range(99) < 80) w.modulus[0] = 1'b1;
    if (w.modulus < 2) w.modulus = word_t'(3);
    if (kind < 85) begin
      w.value_in = word_t'($urandom_range(32'(w.modulus) - 1, 1));
    end else if (kind < 89) begin
      w.value_in = '0;
    end else if (kind < 96) begin
      w.value_in = word_t'($urandom());
    end else begin
      w.modulus  = word_t'($urandom_range(1, 0));
      w.value_in = rand_bits(width);
    end
    return w;
  endfunction

  in_word_t directed[$];

  initial begin
    start = 1'b0;
    item  = '0;
    rst   = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: extremes, zero value, tiny and zero moduli, values at or
    // above the modulus, shared factors and the longest quotient chain.
    directed.push_back('{value_in: word_t'(0), modulus: WORD_MAX});
    directed.push_back('{value_in: word_t'(0), modulus: word_t'(0)});
    directed.push_back('{value_in: word_t'(0), modulus: word_t'(7)});
    directed.push_back('{value_in: word_t'(1), modulus: WORD_MAX});
    directed.push_back('{value_in: word_t'(WORD_MAX - 1), modulus: WORD_MAX});
    directed.push_back('{value_in: WORD_MAX, modulus: WORD_MAX});
    directed.push_back('{value_in: WORD_MAX, modulus: word_t'(WORD_MAX - 1)});
    directed.push_back('{value_in: word_t'(10), modulus: word_t'(7)});
    directed.push_back('{value_in: WORD_MAX, modulus: word_t'(3)});
    directed.push_back('{value_in: word_t'(5), modulus: word_t'(0)});
    directed.push_back('{value_in: word_t'(1), modulus: word_t'(0)});
    directed.push_back('{value_in: word_t'(1), modulus: word_t'(1)});
    directed.push_back('{value_in: word_t'(3), modulus: word_t'(1)});
    directed.push_back('{value_in: word_t'(1), modulus: word_t'(2)});
    directed.push_back('{value_in: word_t'(6), modulus: word_t'(9)});
    directed.push_back('{value_in: word_t'(1134903170), modulus: word_t'(1836311903)});
    directed.push_back('{value_in: word_t'(1836311903), modulus: word_t'(1134903170)});
    directed.push_back('{value_in: word_t'(31'h2AAA_AAAA), modulus: word_t'(31'h5555_5555)});
    directed.push_back('{value_in: word_t'(31'h5555_5555), modulus: WORD_MAX});
    directed.push_back('{value_in: word_t'(2), modulus: word_t'(65537)});
    directed.push_back('{value_in: word_t'(12345), modulus: word_t'(1000003)});
    foreach (directed[i]) send_word(directed[i], pick_gap(i));

    for (int i = 0; i < N_RANDOM; i++) send_word(random_word(), pick_gap(i));

    // Let every result come back, then watch for strays.
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modinv_dp.sv
rtl/modinv_ctrl.sv
rtl/modular_inverse.sv
tb/sv/modinv_checker.sv
tb/sv/tb.sv
